[design/ffsa_pkg.sv]
// Shared types and constants for the first-fit segment allocator.
// No dependencies.
package ffsa_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int MAX_SEGMENTS = 16;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int START_W = $clog2(POOL_BYTES);
  localparam int LEN_W  = $clog2(POOL_BYTES + 1);
  localparam int SIZE_W = 13;
  localparam int OFS_W  = 12;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_OFFSET = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [OFS_W-1:0]  release_offset;
  } ffsa_req_t;

  typedef struct packed {
    logic [OFS_W-1:0] grant_offset;
    status_t          status;
  } ffsa_rsp_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               used;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_INS,
    S_MARK,
    S_REL_NX,
    S_REL_SH,
    S_FIN
  } ffsa_state_t;

endpackage

[design/ffsa_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/ffsa_ctrl.sv]
// Request sequencer: scans, shifts and merges the segment table held in RAM.
// Depends on ffsa_pkg.
module ffsa_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ffsa_pkg::ffsa_req_t     in_data,
  input  logic                    res_ready,
  output logic                    res_valid,
  output ffsa_pkg::ffsa_rsp_t     res_data,
  output logic                    we,
  output logic [ffsa_pkg::IDX_W-1:0] waddr,
  output ffsa_pkg::seg_t          wdata,
  output logic [ffsa_pkg::IDX_W-1:0] raddr,
  input  ffsa_pkg::seg_t          rdata
);
  import ffsa_pkg::*;

  ffsa_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] dst_r, dst_nxt;
  logic [1:0]       n_r, n_nxt;
  seg_t             cur_r, cur_nxt;
  seg_t             prev_r, prev_nxt;
  ffsa_req_t        req_r, req_nxt;
  ffsa_rsp_t        rsp_r, rsp_nxt;

  logic             hit;
  logic [LEN_W-1:0] size_l;
  logic [LEN_W-1:0] rest;
  logic             merge_l, merge_r;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] src;
  logic [1:0]       n_c;
  logic [LEN_W-1:0] sum_len;

  assign size_l = LEN_W'(req_r.request_size);
  assign rest   = rdata.len - size_l;

  always_comb begin
    if (req_r.kind == KIND_ALLOC) begin
      hit = !rdata.used && (32'(rdata.len) >= 32'(req_r.request_size));
    end else begin
      hit = rdata.used && (32'(rdata.start) == 32'(req_r.release_offset));
    end
  end

  assign merge_l = (idx_r != '0) && !prev_r.used;
  assign merge_r = ((idx_r + 1'b1) < cnt_r) && !rdata.used;
  assign base    = merge_l ? idx_r - 1'b1 : idx_r;
  assign n_c     = 2'(merge_l) + 2'(merge_r);
  assign src     = base + 1'b1 + CNT_W'(n_c);
  assign sum_len = (merge_l ? prev_r.len : '0) + cur_r.len + (merge_r ? rdata.len : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= CNT_W'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    idx_r  <= idx_nxt;
    j_r    <= j_nxt;
    dst_r  <= dst_nxt;
    n_r    <= n_nxt;
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    req_r  <= req_nxt;
    rsp_r  <= rsp_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    dst_nxt   = dst_r;
    n_nxt     = n_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    req_nxt   = req_r;
    rsp_nxt   = rsp_r;
    in_stall  = 1'b1;
    res_valid = 1'b0;
    we        = 1'b0;
    waddr     = idx_r[IDX_W-1:0];
    wdata     = rdata;
    raddr     = IDX_W'(idx_r + 1'b1);

    case (state_r)
      S_INIT: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = '{start: '0, len: LEN_W'(POOL_BYTES), used: 1'b0};
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        raddr    = '0;
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          rsp_nxt = '{grant_offset: '0, status: ST_NO_SPACE};
          if (in_data.kind == KIND_ALLOC && in_data.request_size == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          cur_nxt = rdata;
          if (req_r.kind == KIND_RELEASE) begin
            state_nxt = S_REL_NX;
          end else if (rest == '0) begin
            state_nxt = S_MARK;
          end else if (cnt_r == CNT_W'(MAX_SEGMENTS)) begin
            rsp_nxt   = '{grant_offset: '0, status: ST_TABLE_FULL};
            state_nxt = S_FIN;
          end else if (cnt_r - 1'b1 >= idx_r + 1'b1) begin
            j_nxt     = cnt_r - 1'b1;
            raddr     = IDX_W'(cnt_r - 1'b1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_INS;
          end
        end else begin
          prev_nxt = rdata;
          if (idx_r + 1'b1 >= cnt_r) begin
            rsp_nxt = '{grant_offset: '0,
                        status: (req_r.kind == KIND_ALLOC) ? ST_NO_SPACE : ST_BAD_OFFSET};
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = IDX_W'(j_r + 1'b1);
        wdata = rdata;
        raddr = IDX_W'(j_r - 1'b1);
        if (j_r > idx_r + 1'b1) begin
          j_nxt = j_r - 1'b1;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        we        = 1'b1;
        waddr     = IDX_W'(idx_r + 1'b1);
        wdata     = '{start: START_W'(cur_r.start + req_r.request_size),
                      len: cur_r.len - size_l, used: 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        we        = 1'b1;
        waddr     = idx_r[IDX_W-1:0];
        wdata     = '{start: cur_r.start, len: size_l, used: 1'b1};
        rsp_nxt   = '{grant_offset: OFS_W'(cur_r.start), status: ST_OK};
        state_nxt = S_FIN;
      end
      S_REL_NX: begin
        we      = 1'b1;
        waddr   = base[IDX_W-1:0];
        wdata   = '{start: merge_l ? prev_r.start : cur_r.start, len: sum_len, used: 1'b0};
        rsp_nxt = '{grant_offset: '0, status: ST_OK};
        n_nxt   = n_c;
        raddr   = IDX_W'(src);
        if (n_c != '0 && src < cnt_r) begin
          j_nxt     = src;
          dst_nxt   = base + 1'b1;
          state_nxt = S_REL_SH;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(n_c);
          state_nxt = S_FIN;
        end
      end
      S_REL_SH: begin
        we      = 1'b1;
        waddr   = dst_r[IDX_W-1:0];
        wdata   = rdata;
        raddr   = IDX_W'(j_r + 1'b1);
        j_nxt   = j_r + 1'b1;
        dst_nxt = dst_r + 1'b1;
        if (j_r + 1'b1 >= cnt_r) begin
          cnt_nxt   = cnt_r - CNT_W'(n_r);
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_data = rsp_r;

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != '0 && cnt_r <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < cnt_r)
    else $error("scan beyond table");
  a_res_once: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !res_valid)
    else $error("duplicate result");
  a_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> cnt_r < CNT_W'(MAX_SEGMENTS))
    else $error("insert into full table");
`endif

endmodule

[design/first_fit_segment_allocator.sv]
// Top level of the first-fit segment allocator: sequencer, table RAM, result register.
// Depends on ffsa_pkg, ffsa_ram and ffsa_ctrl.
// One request at a time. An allocation scans the table one entry per cycle until
// the first fitting free segment, then shifts later entries up one per cycle to
// open a slot for the remainder; a release scans to the segment, merges with its
// free neighbors and shifts later entries down one per cycle. A result waits in the
// sequencer while out_stall holds the result register full; the table RAM has a single
// read and a single write port. After reset the S_INIT state initializes the table
// before the first request is taken.
module first_fit_segment_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffsa_pkg::ffsa_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffsa_pkg::ffsa_rsp_t out_data
);
  import ffsa_pkg::*;

  logic             res_ready, res_valid;
  ffsa_rsp_t        res_data;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  seg_t             wdata, rdata;
  logic [SEG_W-1:0] rdata_raw;
  logic             out_valid_r;
  ffsa_rsp_t        out_data_r;

  assign res_ready = !out_valid_r || !out_stall;
  assign rdata     = seg_t'(rdata_raw);

  ffsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  ffsa_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (SEG_W'(wdata)),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sim/ffsa_scoreboard.sv]
// Scoreboard for the first-fit segment allocator: segment table predictor and response check.
// Depends on ffsa_pkg.
`timescale 1ns / 100ps
class ffsa_scoreboard;
  logic [11:0] seg_start [16];
  logic [12:0] seg_len [16];
  bit          seg_used [16];
  int          seg_cnt;
  ffsa_pkg::ffsa_rsp_t pending [$];
  int          fails;

  function void clear();
    for (int i = 0; i < 16; i++) begin
      seg_start[i] = 0; seg_len[i] = 0; seg_used[i] = 0;
    end
    seg_len[0] = 13'(ffsa_pkg::POOL_BYTES);
    seg_cnt = 1;
    pending.delete();
    fails = 0;
  endfunction

  function int live_count();
    return seg_cnt;
  endfunction

  function void coalesce();
    int i;
    i = 0;
    while (i + 1 < seg_cnt) begin
      if (!seg_used[i] && !seg_used[i+1] &&
          ({1'b0, seg_start[i]} + seg_len[i] == {1'b0, seg_start[i+1]})) begin
        seg_len[i] += seg_len[i+1];
        for (int k = i + 1; k + 1 < seg_cnt; k++) begin
          seg_start[k] = seg_start[k+1]; seg_len[k] = seg_len[k+1];
          seg_used[k] = seg_used[k+1];
        end
        seg_cnt--;
        seg_start[seg_cnt] = 0; seg_len[seg_cnt] = 0; seg_used[seg_cnt] = 0;
      end else i++;
    end
  endfunction

  function void note_request(ffsa_pkg::ffsa_req_t r);
    ffsa_pkg::ffsa_rsp_t e;
    int i;
    logic [12:0] rest;
    e.grant_offset = 0;
    e.status = ffsa_pkg::ST_NO_SPACE;
    if (r.kind == ffsa_pkg::KIND_ALLOC) begin
      if (r.request_size != 0) begin
        for (i = 0; i < seg_cnt; i++)
          if (!seg_used[i] && seg_len[i] >= r.request_size) break;
        if (i < seg_cnt) begin
          rest = seg_len[i] - r.request_size;
          if (rest != 0 && seg_cnt >= 16) e.status = ffsa_pkg::ST_TABLE_FULL;
          else begin
            if (rest != 0) begin
              for (int k = seg_cnt; k > i + 1; k--) begin
                seg_start[k] = seg_start[k-1]; seg_len[k] = seg_len[k-1];
                seg_used[k] = seg_used[k-1];
              end
              seg_start[i+1] = seg_start[i] + r.request_size[11:0];
              seg_len[i+1] = rest; seg_used[i+1] = 0;
              seg_cnt++;
            end
            seg_len[i] = r.request_size; seg_used[i] = 1;
            e.grant_offset = seg_start[i];
            e.status = ffsa_pkg::ST_OK;
          end
        end
      end
    end else begin
      e.status = ffsa_pkg::ST_BAD_OFFSET;
      for (i = 0; i < seg_cnt; i++)
        if (seg_used[i] && seg_start[i] == r.release_offset) begin
          seg_used[i] = 0;
          coalesce();
          e.status = ffsa_pkg::ST_OK;
          break;
        end
    end
    pending.push_back(e);
  endfunction

  function void check_response(ffsa_pkg::ffsa_rsp_t got);
    ffsa_pkg::ffsa_rsp_t e;
    if (pending.size() == 0) begin
      $error("unexpected response %h", got);
      fails++;
      return;
    end
    e = pending.pop_front();
    if (got.grant_offset !== e.grant_offset) begin
      $error("grant_offset expected %0d actual %0d", e.grant_offset, got.grant_offset);
      fails++;
    end
    if (got.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, got.status);
      fails++;
    end
  endfunction

  // random used offset for well-formed releases, else a random offset
  function logic [11:0] pick_used();
    int n;
    n = 0;
    for (int i = 0; i < seg_cnt; i++) if (seg_used[i]) n++;
    if (n == 0) return 12'($urandom_range(0, 4095));
    n = $urandom_range(0, n - 1);
    for (int i = 0; i < seg_cnt; i++)
      if (seg_used[i]) begin
        if (n == 0) return seg_start[i];
        n--;
      end
    return 0;
  endfunction
endclass

[sim/tb_top.sv]
// Testbench top for first_fit_segment_allocator: drives requests, stalls responses.
// Depends on ffsa_pkg, ffsa_scoreboard and the design.
`timescale 1ns / 100ps
module tb_top;
  import ffsa_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  ffsa_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  ffsa_rsp_t out_data;

  ffsa_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;
  int quiet = 0;
  bit done = 0;

  always #5 clk = ~clk;

  first_fit_segment_allocator DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_response(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < recv_stall);
  end

  always @(posedge clk) begin
    if (quiet > 20000 && !done) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(ffsa_req_t r);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_alloc(int sz);
    ffsa_req_t r;
    r.kind = KIND_ALLOC;
    r.request_size = 13'(sz);
    r.release_offset = 12'($urandom_range(0, 4095));
    send(r);
  endtask

  task automatic send_release(logic [11:0] ofs);
    ffsa_req_t r;
    r.kind = KIND_RELEASE;
    r.request_size = 13'($urandom_range(0, 8191));
    r.release_offset = ofs;
    send(r);
  endtask

  task automatic random_item();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) begin
      if ($urandom_range(0, 3) == 0) send_alloc($urandom_range(1, 1024));
      else send_alloc($urandom_range(1, 300));
    end else if (p < 85) send_release(sb.pick_used());
    else if (p < 90) send_alloc($urandom_range(0, 8191));
    else if (p < 93) send_alloc(0);
    else send_release(12'($urandom_range(0, 4095)));
  endtask

  initial begin
    sb.clear();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed
    send_alloc(0);
    send_alloc(4097);
    send_alloc(8191);
    send_release(0);
    send_release(4095);
    send_alloc(4096);
    send_release(0);
    for (int i = 0; i < 15; i++) send_alloc(1);
    send_alloc(10);
    send_alloc(4081);
    send_release(5);
    send_release(3);
    send_release(4);
    send_release(2);
    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 52 : (ph == 3) ? 27 : 0;
      recv_stall = (ph == 2) ? 52 : (ph == 3) ? 27 : 0;
      if (ph == 0) begin
        hold_off = 1;
        fork
          begin repeat (300) @(posedge clk); hold_off = 0; end
          begin repeat (8) random_item(); in_valid <= 0; end
        join
      end
      repeat (100) random_item();
    end
    in_valid <= 0;
    send_idle = 0;
    recv_stall = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    done = 1;
    if (sb.fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

[first_fit_segment_allocator.f]
design/ffsa_pkg.sv
design/ffsa_ram.sv
design/ffsa_ctrl.sv
design/first_fit_segment_allocator.sv
sim/ffsa_scoreboard.sv
sim/tb_top.sv
